// ----- rtl/csu_pkg.sv -----
// Shared types and constants for the cosine similarity unit.
package csu_pkg;

    localparam int ACC_W   = 48;
    localparam int PROD_W  = 2 * ACC_W;
    localparam int ROOT_W  = ACC_W;
    localparam int NUM_W   = ACC_W + 15;
    localparam int ALU_W   = ACC_W + 3;
    localparam int CNT_W   = 6;
    localparam int Q_W     = 17;

    typedef struct packed {
        logic signed [15:0] a_elem;
        logic signed [15:0] b_elem;
        logic               last;
    } elem_t;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               zero_norm;
    } result_t;

    // Running sums handed from the accumulators to the sequencer.
    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] norm_a;
        logic [ACC_W-1:0] norm_b;
    } acc_t;

    // One operation for the shared adder/subtractor.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;
    } alu_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_SQRT = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } csu_state_t;

endpackage

// ----- rtl/csu_addsub.sv -----
// Shared adder/subtractor used by the multiply, root and divide steps.
module csu_addsub (
    input  csu_pkg::alu_req_t req,
    output csu_pkg::alu_rsp_t rsp
);

    logic [csu_pkg::ALU_W-1:0] b_op;
    logic [csu_pkg::ALU_W:0]   sum;

    // For a subtraction the carry out is high when a >= b.
    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = {1'b0, req.a} + {1'b0, b_op} + {{csu_pkg::ALU_W{1'b0}}, req.sub};

    assign rsp.res   = sum[csu_pkg::ALU_W-1:0];
    assign rsp.carry = sum[csu_pkg::ALU_W];

endmodule

// ----- rtl/csu_accum.sv -----
// Dot product and squared norm accumulators, one element pair per cycle in which fire is high.
module csu_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  csu_pkg::elem_t      elem,
    output csu_pkg::acc_t       sums
);

    logic [csu_pkg::ACC_W-1:0] dot_reg, norm_a_reg, norm_b_reg;
    logic [csu_pkg::ACC_W-1:0] dot_next, norm_a_next, norm_b_next;
    logic signed [31:0]        p_ab, p_aa, p_bb;

    assign p_ab = elem.a_elem * elem.b_elem;
    assign p_aa = elem.a_elem * elem.a_elem;
    assign p_bb = elem.b_elem * elem.b_elem;

    // Sums including the current pair; the sequencer takes these on the last pair.
    assign sums.dot    = dot_reg + {{(csu_pkg::ACC_W-32){p_ab[31]}}, p_ab};
    assign sums.norm_a = norm_a_reg + {{(csu_pkg::ACC_W-32){1'b0}}, p_aa};
    assign sums.norm_b = norm_b_reg + {{(csu_pkg::ACC_W-32){1'b0}}, p_bb};

    always_comb
    begin
        dot_next    = dot_reg;
        norm_a_next = norm_a_reg;
        norm_b_next = norm_b_reg;
        if (fire)
        begin
            if (elem.last)
            begin
                dot_next    = '0;
                norm_a_next = '0;
                norm_b_next = '0;
            end
            else
            begin
                dot_next    = sums.dot;
                norm_a_next = sums.norm_a;
                norm_b_next = sums.norm_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg    <= '0;
            norm_a_reg <= '0;
            norm_b_reg <= '0;
        end
        else
        begin
            dot_reg    <= dot_next;
            norm_a_reg <= norm_a_next;
            norm_b_reg <= norm_b_next;
        end
    end

endmodule

// ----- rtl/csu_seq.sv -----
// Sequencer for the norm product, integer root and division on one shared adder.
module csu_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  csu_pkg::acc_t      sums,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_taken,
    output csu_pkg::result_t   res
);

    localparam int AW = csu_pkg::ACC_W;
    localparam int XW = csu_pkg::ALU_W;

    csu_pkg::csu_state_t state_reg, state_next;
    logic [csu_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]              mcand_reg, mcand_next;
    logic [csu_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [XW-1:0]              rem_reg, rem_next;
    logic [csu_pkg::ROOT_W-1:0] root_reg, root_next;
    logic [csu_pkg::NUM_W-1:0]  num_reg, num_next;
    logic [csu_pkg::Q_W-1:0]    q_reg, q_next;
    logic                       ovf_reg, ovf_next;
    logic                       neg_reg, neg_next;
    logic                       zn_reg, zn_next;

    csu_pkg::alu_req_t req;
    csu_pkg::alu_rsp_t rsp;

    logic [AW-1:0]           mag;
    logic [XW-1:0]           rem_sh;
    logic [csu_pkg::Q_W-1:0] q_sat;
    logic [csu_pkg::Q_W-1:0] q_neg;

    csu_addsub u_alu (
        .req (req),
        .rsp (rsp)
    );

    assign mag = sums.dot[AW-1] ? (~sums.dot + {{(AW-1){1'b0}}, 1'b1}) : sums.dot;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        num_next   = num_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        zn_next    = zn_reg;
        req        = '0;
        rem_sh     = '0;

        unique case (state_reg)
            csu_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mcand_next = sums.norm_a;
                    prod_next  = {{AW{1'b0}}, sums.norm_b};
                    num_next   = {mag, 15'd0};
                    neg_next   = sums.dot[AW-1];
                    cnt_next   = csu_pkg::CNT_W'(AW - 1);
                    if (sums.norm_a == '0 || sums.norm_b == '0)
                    begin
                        zn_next    = 1'b1;
                        state_next = csu_pkg::S_DONE;
                    end
                    else
                    begin
                        zn_next    = 1'b0;
                        state_next = csu_pkg::S_MUL;
                    end
                end
            end
            csu_pkg::S_MUL:
            begin
                // Shift-and-add: add the multiplicand to the upper half when the low bit is set, then shift right.
                req.a   = {3'd0, prod_reg[csu_pkg::PROD_W-1:AW]};
                req.b   = {3'd0, mcand_reg};
                req.sub = 1'b0;
                if (prod_reg[0])
                    prod_next = {rsp.res[AW:0], prod_reg[AW-1:1]};
                else
                    prod_next = {1'b0, prod_reg[csu_pkg::PROD_W-1:1]};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = csu_pkg::CNT_W'(AW - 1);
                    state_next = csu_pkg::S_SQRT;
                end
            end
            csu_pkg::S_SQRT:
            begin
                // Restoring root: bring in two radicand bits, try root*4+1.
                rem_sh  = {rem_reg[XW-3:0], prod_reg[csu_pkg::PROD_W-1 -: 2]};
                req.a   = rem_sh;
                req.b   = {1'b0, root_reg, 2'b01};
                req.sub = 1'b1;
                if (rsp.carry)
                begin
                    rem_next  = rsp.res;
                    root_next = {root_reg[AW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[AW-2:0], 1'b0};
                end
                prod_next = {prod_reg[csu_pkg::PROD_W-3:0], 2'b00};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                    cnt_next   = csu_pkg::CNT_W'(csu_pkg::NUM_W - 1);
                    state_next = csu_pkg::S_DIV;
                end
            end
            csu_pkg::S_DIV:
            begin
                // Restoring division; quotient bits beyond Q_W only set the overflow flag.
                rem_sh  = {2'b00, rem_reg[AW-1:0], num_reg[csu_pkg::NUM_W-1]};
                req.a   = rem_sh;
                req.b   = {3'd0, root_reg};
                req.sub = 1'b1;
                rem_next = rsp.carry ? rsp.res : rem_sh;
                q_next   = {q_reg[csu_pkg::Q_W-2:0], rsp.carry};
                ovf_next = ovf_reg | q_reg[csu_pkg::Q_W-1];
                num_next = {num_reg[csu_pkg::NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = csu_pkg::S_DONE;
            end
            csu_pkg::S_DONE:
            begin
                if (res_taken)
                    state_next = csu_pkg::S_IDLE;
            end
            default:
            begin
                state_next = csu_pkg::S_IDLE;
            end
        endcase
    end

    // Saturate the quotient magnitude to the signed Q1.15 range.
    always_comb
    begin
        if (neg_reg)
            q_sat = (ovf_reg || q_reg > 17'd32768) ? 17'd32768 : q_reg;
        else
            q_sat = (ovf_reg || q_reg > 17'd32767) ? 17'd32767 : q_reg;
        q_neg = neg_reg ? (17'd0 - q_sat) : q_sat;
    end

    assign res.similarity = zn_reg ? 16'sd0 : signed'(q_neg[15:0]);
    assign res.zero_norm  = zn_reg;
    assign res_valid      = (state_reg == csu_pkg::S_DONE);
    assign idle           = (state_reg == csu_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csu_pkg::S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        ovf_reg   <= ovf_next;
        neg_reg   <= neg_next;
        zn_reg    <= zn_next;
    end

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csu_pkg::S_MUL && cnt_reg != '0)
        |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("multiply step counter did not decrement");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csu_pkg::S_DIV)
        |-> (rem_reg[XW-1:AW] == '0 && rem_reg[AW-1:0] < root_reg))
        else $error("division remainder not below the root");

    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csu_pkg::S_DIV) |-> (root_reg != '0))
        else $error("zero root reached the divider");

    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csu_pkg::S_IDLE && start && (sums.norm_a == '0 || sums.norm_b == '0))
        |=> (state_reg == csu_pkg::S_DONE && res.zero_norm && res.similarity == 16'sd0))
        else $error("zero norm did not give an immediate zero result");

endmodule

// ----- rtl/cosine_similarity_unit.sv -----
// Streaming cosine similarity unit: takes one element pair per word and, on the
// last pair, returns the signed Q1.15 similarity of the two vectors. Ordinary
// pairs are accepted one per cycle into 48-bit accumulators. A pair marked last
// starts the final computation, which runs through one shared 51-bit
// adder/subtractor: 48 multiply steps for the norm product, 48 steps of the
// integer square root and 63 division steps, so the input is held off after a
// last pair while these run (they are skipped when either norm is zero) and
// until the output register can take the result. A finished result waits in its
// own register, so the next vector may stream in while it is still unread.
module cosine_similarity_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              elem_valid,
    output logic              elem_ready,
    input  csu_pkg::elem_t    elem,
    output logic              result_valid,
    input  logic              result_ready,
    output csu_pkg::result_t  result
);

    logic              fire;
    logic              seq_idle;
    logic              res_valid;
    logic              res_taken;
    csu_pkg::acc_t     sums;
    csu_pkg::result_t  res;
    csu_pkg::result_t  result_reg;
    logic              result_valid_reg, result_valid_next;

    assign elem_ready = seq_idle;
    assign fire       = elem_valid & elem_ready;

    csu_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .elem  (elem),
        .sums  (sums)
    );

    csu_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fire & elem.last),
        .sums      (sums),
        .idle      (seq_idle),
        .res_valid (res_valid),
        .res_taken (res_taken),
        .res       (res)
    );

    // The output register loads when it is empty or being emptied this cycle.
    assign res_taken = res_valid & (~result_valid_reg | result_ready);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res_taken)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_taken)
            result_reg <= res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- tb/tb_cosine_similarity_unit.sv -----
// Self-checking testbench for the streaming cosine similarity unit.
`timescale 1ns / 1ps

module tb_cosine_similarity_unit;

    localparam int  MAX_LEN       = 1024;
    localparam int  GAP_MAX       = 11;
    localparam int  DRAIN_CYCLES  = 400;
    localparam int  HOLD_CYCLES   = 700;
    localparam int  RANDOM_PAIRS  = 350;
    localparam longint CYCLE_LIMIT = 400_000;

    typedef enum int {
        VEC_INDEPENDENT,
        VEC_EQUAL,
        VEC_OPPOSITE,
        VEC_HALF,
        VEC_A_ZERO,
        VEC_B_ZERO
    } vec_shape_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             elem_valid = 1'b0;
    logic             elem_ready;
    csu_pkg::elem_t   elem = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    csu_pkg::result_t result;

    // Running sums of the predictor, same widths and wrap as the hardware.
    logic [csu_pkg::ACC_W-1:0] dot_sum = '0;
    logic [csu_pkg::ACC_W-1:0] norm_a_sum = '0;
    logic [csu_pkg::ACC_W-1:0] norm_b_sum = '0;

    csu_pkg::result_t pending_similarities[$];

    bit     tx_idle = 1'b1;
    bit     rx_idle = 1'b1;
    int     stall_cycles = 0;
    int     errors = 0;
    int     pairs_sent = 0;
    int     vectors_sent = 0;
    int     results_checked = 0;
    int     zero_norm_seen = 0;
    int     saturated_seen = 0;
    longint cycle_count = 0;

    cosine_similarity_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .elem_valid   (elem_valid),
        .elem_ready   (elem_ready),
        .elem         (elem),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // floor(sqrt(x * y)) by bit-by-bit trial squaring over the full product.
    function automatic logic [csu_pkg::ACC_W-1:0] root_of_norms(
        logic [csu_pkg::ACC_W-1:0] x, logic [csu_pkg::ACC_W-1:0] y);
        logic [2*csu_pkg::ACC_W-1:0] target;
        logic [2*csu_pkg::ACC_W-1:0] square;
        logic [csu_pkg::ACC_W-1:0]   root;
        logic [csu_pkg::ACC_W-1:0]   trial;
        int                          i;
        target = {{csu_pkg::ACC_W{1'b0}}, x} * {{csu_pkg::ACC_W{1'b0}}, y};
        root = '0;
        for (i = csu_pkg::ACC_W - 1; i >= 0; i--) begin
            trial = root | (48'd1 << i);
            square = {{csu_pkg::ACC_W{1'b0}}, trial} * {{csu_pkg::ACC_W{1'b0}}, trial};
            if (square <= target)
                root = trial;
        end
        return root;
    endfunction

    // Folds one accepted pair into the sums; a last pair yields one expected result.
    function automatic void absorb_pair(csu_pkg::elem_t word);
        logic signed [15:0]        av;
        logic signed [15:0]        bv;
        logic signed [31:0]        ab;
        logic signed [31:0]        aa;
        logic signed [31:0]        bb;
        logic [csu_pkg::ACC_W-1:0] root;
        logic [csu_pkg::ACC_W-1:0] mag;
        logic [63:0]               quo;
        csu_pkg::result_t          outcome;
        av = word.a_elem;
        bv = word.b_elem;
        ab = av * bv;
        aa = av * av;
        bb = bv * bv;
        dot_sum    = dot_sum + {{16{ab[31]}}, ab};
        norm_a_sum = norm_a_sum + {16'd0, aa};
        norm_b_sum = norm_b_sum + {16'd0, bb};
        pairs_sent++;
        if (!word.last)
            return;
        outcome = '0;
        if (norm_a_sum == 0 || norm_b_sum == 0) begin
            outcome.zero_norm = 1'b1;
        end else begin
            root = root_of_norms(norm_a_sum, norm_b_sum);
            if (root == 0)
                root = 1;
            mag = dot_sum[csu_pkg::ACC_W-1] ? (48'd0 - dot_sum) : dot_sum;
            quo = {1'b0, mag, 15'd0} / {16'd0, root};
            if (dot_sum[csu_pkg::ACC_W-1]) begin
                if (quo > 64'd32768)
                    quo = 64'd32768;
                outcome.similarity = -quo[15:0];
            end else begin
                if (quo > 64'd32767)
                    quo = 64'd32767;
                outcome.similarity = quo[15:0];
            end
        end
        pending_similarities.push_back(outcome);
        vectors_sent++;
        dot_sum    = '0;
        norm_a_sum = '0;
        norm_b_sum = '0;
    endfunction

    // Offers one word, after a random gap when tx_idle is set, and returns at the edge that accepts it.
    task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                             input logic last);
        csu_pkg::elem_t word;
        int             gap;
        word.a_elem = a;
        word.b_elem = b;
        word.last   = last;
        gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            elem_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem_valid <= 1'b1;
        elem <= word;
        @(posedge clk);
        while (!elem_ready)
            @(posedge clk);
        absorb_pair(word);
    endtask

    function automatic logic signed [15:0] pick_value();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'(int'(raw[3:0]) - 8);
            default: return raw[15:0];
        endcase
    endfunction

    task automatic send_vector(input int len, input vec_shape_t shape);
        logic signed [15:0] a;
        logic signed [15:0] b;
        int                 i;
        for (i = 0; i < len; i++) begin
            a = pick_value();
            b = pick_value();
            case (shape)
                VEC_EQUAL:    b = a;
                VEC_OPPOSITE: b = (a == 16'sh8000) ? 16'sh7FFF : -a;
                VEC_HALF:     b = a >>> 1;
                VEC_A_ZERO:   a = '0;
                VEC_B_ZERO:   b = '0;
                default:      ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    function automatic vec_shape_t pick_shape();
        case ($urandom_range(0, 11))
            7:       return VEC_EQUAL;
            8:       return VEC_OPPOSITE;
            9:       return VEC_HALF;
            10:      return VEC_A_ZERO;
            11:      return VEC_B_ZERO;
            default: return VEC_INDEPENDENT;
        endcase
    endfunction

    function automatic int pick_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(25, 200);
        return $urandom_range(1, 24);
    endfunction

    task automatic test_directed_extremes();
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh7FFF, 1'b1);
        send_pair(16'sh7FFF, 16'sh8000, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, 16'sd3, 1'b1);
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
    endtask

    task automatic test_zero_norm();
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sh8000, 1'b1);
        send_pair(16'sh7FFF, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd5, 1'b0);
        send_pair(16'sd0, -16'sd7, 1'b1);
    endtask

    // Identical, opposite or proportional vectors bring the floored root down to the dot product's magnitude.
    task automatic test_saturation();
        send_pair(16'sd1234, 16'sd1234, 1'b0);
        send_pair(-16'sd77, -16'sd77, 1'b0);
        send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_pair(16'sd900, -16'sd900, 1'b0);
        send_pair(-16'sd3, 16'sd3, 1'b0);
        send_pair(16'sh7FFF, -16'sh7FFF, 1'b1);
        send_pair(16'sd100, 16'sd200, 1'b0);
        send_pair(-16'sd50, -16'sd100, 1'b1);
    endtask

    task automatic test_full_rate_stream();
        int start;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        start = pairs_sent;
        while (pairs_sent - start < 200)
            send_vector($urandom_range(1, 12), pick_shape());
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // The receiver stops for a long stretch while short vectors keep coming,
    // so the result register fills and the input must stall.
    task automatic test_output_backpressure();
        int n;
        tx_idle = 1'b0;
        stall_cycles = HOLD_CYCLES;
        for (n = 0; n < 8; n++)
            send_vector($urandom_range(1, 3), pick_shape());
        tx_idle = 1'b1;
    endtask

    task automatic test_random_vectors();
        int start;
        start = pairs_sent;
        while (pairs_sent - start < RANDOM_PAIRS) begin
            if ($urandom_range(0, 7) == 0) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end
            send_vector(pick_length(), pick_shape());
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Full-length vector of extreme values, MAX_LEN pairs long.
    task automatic test_max_length_vector();
        int i;
        tx_idle = 1'b0;
        for (i = 0; i < MAX_LEN; i++)
            send_pair(16'sh7FFF, 16'sh8000, i == MAX_LEN - 1);
        tx_idle = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_zero_norm();
        test_saturation();
        test_full_rate_stream();
        test_output_backpressure();
        test_random_vectors();
        test_max_length_vector();
        elem_valid <= 1'b0;
        while (pending_similarities.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d element pairs in %0d vectors; checked %0d results", pairs_sent,
                 vectors_sent, results_checked);
        $display("(%0d zero-norm, %0d at full scale), with a full-length vector and stalls.",
                 zero_norm_seen, saturated_seen);
        if (errors == 0 && pending_similarities.size() == 0)
            $display("** cosine_similarity_unit: PASSED **");
        else
            $display("** cosine_similarity_unit: FAILED **");
        $finish;
    end

    // Result side: random hold-off per word when rx_idle is set, plus the long stall on request.
    initial begin
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (stall_cycles > 0) begin
                result_ready <= 1'b0;
                repeat (stall_cycles) @(posedge clk);
                stall_cycles = 0;
            end
            gap = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
            if (gap > 0) begin
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_valid && result_ready) && stall_cycles == 0);
        end
    end

    always @(posedge clk) begin
        csu_pkg::result_t want;
        if (rst_n && result_valid && result_ready) begin
            if (pending_similarities.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d zero_norm %0b",
                         $time, result.similarity, result.zero_norm);
                errors++;
            end else begin
                want = pending_similarities.pop_front();
                results_checked++;
                if (want.zero_norm)
                    zero_norm_seen++;
                if (want.similarity == 16'sh7FFF || want.similarity == 16'sh8000)
                    saturated_seen++;
                if (result.similarity !== want.similarity) begin
                    $display("%0t: similarity mismatch: expected %0d, actual %0d",
                             $time, want.similarity, result.similarity);
                    errors++;
                end
                if (result.zero_norm !== want.zero_norm) begin
                    $display("%0t: zero_norm mismatch: expected %0b, actual %0b",
                             $time, want.zero_norm, result.zero_norm);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_similarities.size());
            $display("** cosine_similarity_unit: FAILED **");
            $finish;
        end
    end

endmodule

// ----- cosine_similarity_unit.f -----
rtl/csu_pkg.sv
rtl/csu_addsub.sv
rtl/csu_accum.sv
rtl/csu_seq.sv
rtl/cosine_similarity_unit.sv
tb/tb_cosine_similarity_unit.sv
